// ----- rtl/voxel_shape_fill_engine_defines.svh -----
// ----------------------------------------------------------------------------
// voxel_shape_fill_engine_defines
// Assertion macros shared by the voxel engine RTL.
// ----------------------------------------------------------------------------
`ifndef VOXEL_SHAPE_FILL_ENGINE_DEFINES_SVH
`define VOXEL_SHAPE_FILL_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define VSF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vsf assertion failed");
`define VSF_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("vsf assertion failed");
`else
`define VSF_ASSERT(name, prop)
`define VSF_ASSERT_RST(name, prop)
`endif

`endif

// ----- rtl/vsf_pkg.sv -----
// ----------------------------------------------------------------------------
// vsf_pkg
// Types and constants of the voxel shape fill engine.
// ----------------------------------------------------------------------------
package vsf_pkg;

  typedef logic [7:0] coord_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [4:0] pos_x;
    logic [4:0] pos_y;
    logic [4:0] pos_z;
    logic [4:0] span_x;
    logic [4:0] span_y;
    logic [4:0] span_z;
  } cmd_t;

  typedef struct packed {
    logic        voxel_on;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [15:0] touched_count;
  } res_t;

  // one voxel access towards the store
  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    coord_t z;
  } beat_t;

  localparam logic [2:0] KIND_LAST_DRAW = 3'd5;
  localparam logic [2:0] KIND_READ      = 3'd6;

  localparam logic [1:0] SHAPE_BOX       = 2'd0;
  localparam logic [1:0] SHAPE_SPHERE    = 2'd1;
  localparam logic [1:0] SHAPE_ELLIPSOID = 2'd2;

  localparam logic [2:0] REG_RED   = 3'd0;
  localparam logic [2:0] REG_GREEN = 3'd1;
  localparam logic [2:0] REG_BLUE  = 3'd2;
  localparam logic [2:0] REG_ALPHA = 3'd3;

  function automatic coord_t clip_lo(logic box, logic [4:0] p, logic [4:0] s);
    coord_t r;
    if (box) begin
      r = {3'b000, p};
    end else if (p > s) begin
      r = {3'b000, 5'(p - s)};
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic coord_t clip_hi(logic box, logic [4:0] p, logic [4:0] s,
                                     coord_t lim);
    logic [5:0] v;
    coord_t     r;
    v = box ? {1'b0, s} : 6'(p) + 6'(s);
    if (9'(v) > 9'(lim)) begin
      r = lim;
    end else begin
      r = 8'(v);
    end
    return r;
  endfunction

endpackage

// ----- rtl/vsf_store.sv -----
// ----------------------------------------------------------------------------
// vsf_store
// Occupancy and colour memories, one write and one registered read a cycle while busy_o is low.
// Occupancy is swept to zero after reset.
// ----------------------------------------------------------------------------
`include "voxel_shape_fill_engine_defines.svh"

module vsf_store #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          busy_o,
  input  vsf_pkg::beat_t wr_i,
  input  logic          fill_i,
  input  logic [31:0]   colour_i,
  input  vsf_pkg::beat_t rd_i,
  output logic          rd_on_o,
  output logic [31:0]   rd_colour_o
);

  localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

  logic          occ_mem [0:CELLS-1];
  logic [31:0]   col_mem [0:CELLS-1];

  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic [23:0]   wa_full, ra_full;
  logic [AW-1:0] wa, ra;
  logic          rd_on_q;
  logic [31:0]   rd_col_q;

  assign wa_full = (24'(wr_i.x) * 24'(GRID_Y) + 24'(wr_i.y)) * 24'(GRID_Z) + 24'(wr_i.z);
  assign ra_full = (24'(rd_i.x) * 24'(GRID_Y) + 24'(rd_i.y)) * 24'(GRID_Z) + 24'(rd_i.z);
  assign wa = wa_full[AW-1:0];
  assign ra = ra_full[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == LAST) begin
        clr_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      occ_mem[clr_cnt_q] <= 1'b0;
    end else if (wr_i.valid) begin
      occ_mem[wa] <= fill_i;
    end
    if (rd_i.valid) begin
      rd_on_q <= occ_mem[ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid && fill_i) begin
      col_mem[wa] <= colour_i;
    end
    if (rd_i.valid) begin
      rd_col_q <= col_mem[ra];
    end
  end

  assign busy_o      = clr_q;
  assign rd_on_o     = rd_on_q;
  assign rd_colour_o = rd_col_q;

  `VSF_ASSERT(a_no_access_in_clear, clr_q |-> !(wr_i.valid || rd_i.valid))

endmodule

// ----- rtl/vsf_scan.sv -----
// ----------------------------------------------------------------------------
// vsf_scan
// Bounds set-up, voxel scan counters and the pipelined shape test (stages a and b).
// Emits one write beat per voxel inside the shape and counts them.
// ----------------------------------------------------------------------------
module vsf_scan #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  vsf_pkg::cmd_t  cmd_i,
  output vsf_pkg::beat_t beat_o,
  output logic           done_o,
  output logic [15:0]    count_o
);

  localparam vsf_pkg::coord_t MAX_X = 8'(GRID_X - 1);
  localparam vsf_pkg::coord_t MAX_Y = 8'(GRID_Y - 1);
  localparam vsf_pkg::coord_t MAX_Z = 8'(GRID_Z - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_PROD  = 3'd2;
  localparam logic [2:0] ST_LIM   = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [1:0]  shape_q;
  logic        box;
  logic [4:0]  px_q, py_q, pz_q, sx_q, sy_q, sz_q;
  vsf_pkg::coord_t lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q, hi_z_q;
  vsf_pkg::coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic        empty_q;
  logic [9:0]  ax_q, ay_q, az_q;
  logic [19:0] ayaz_q, axaz_q, axay_q;
  logic [29:0] lim_q;
  vsf_pkg::coord_t x_q, y_q, z_q, x_d, y_d, z_d;
  logic        issue;
  vsf_pkg::coord_t dxa, dya, dza;
  logic        a_valid_q, b_valid_q;
  vsf_pkg::coord_t a_x_q, a_y_q, a_z_q, b_x_q, b_y_q, b_z_q;
  logic [9:0]  a_dx2_q, a_dy2_q, a_dz2_q;
  logic [11:0] b_sum_q;
  logic [29:0] b_tx_q, b_ty_q, b_tz_q;
  logic [31:0] b_ell;
  logic        in_shape;
  logic [15:0] count_q;

  assign box  = (shape_q == vsf_pkg::SHAPE_BOX);
  assign lo_x = vsf_pkg::clip_lo(box, px_q, sx_q);
  assign lo_y = vsf_pkg::clip_lo(box, py_q, sy_q);
  assign lo_z = vsf_pkg::clip_lo(box, pz_q, sz_q);
  assign hi_x = vsf_pkg::clip_hi(box, px_q, sx_q, MAX_X);
  assign hi_y = vsf_pkg::clip_hi(box, py_q, sy_q, MAX_Y);
  assign hi_z = vsf_pkg::clip_hi(box, pz_q, sz_q, MAX_Z);

  assign issue = (state_q == ST_SCAN);

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SQ;
        end
      end
      ST_SQ:   state_d = ST_PROD;
      ST_PROD: state_d = ST_LIM;
      ST_LIM: begin
        x_d     = lo_x_q;
        y_d     = lo_y_q;
        z_d     = lo_z_q;
        state_d = empty_q ? ST_DRAIN : ST_SCAN;
      end
      ST_SCAN: begin
        if (z_q != hi_z_q) begin
          z_d = z_q + 1'b1;
        end else begin
          z_d = lo_z_q;
          if (y_q != hi_y_q) begin
            y_d = y_q + 1'b1;
          end else begin
            y_d = lo_y_q;
            if (x_q != hi_x_q) begin
              x_d = x_q + 1'b1;
            end else begin
              state_d = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (!a_valid_q && !b_valid_q) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // distance from the centre, at most 31 inside the bounding box
  assign dxa = (x_q > 8'(px_q)) ? x_q - 8'(px_q) : 8'(px_q) - x_q;
  assign dya = (y_q > 8'(py_q)) ? y_q - 8'(py_q) : 8'(py_q) - y_q;
  assign dza = (z_q > 8'(pz_q)) ? z_q - 8'(pz_q) : 8'(pz_q) - z_q;

  assign b_ell = 32'(b_tx_q) + 32'(b_ty_q) + 32'(b_tz_q);

  always_comb begin
    case (shape_q)
      vsf_pkg::SHAPE_BOX:    in_shape = 1'b1;
      vsf_pkg::SHAPE_SPHERE: in_shape = (b_sum_q <= 12'(ax_q));
      default:               in_shape = (b_ell <= 32'(lim_q));
    endcase
  end

  assign beat_o.valid = b_valid_q && in_shape;
  assign beat_o.x     = b_x_q;
  assign beat_o.y     = b_y_q;
  assign beat_o.z     = b_z_q;
  assign done_o       = (state_q == ST_DRAIN) && !a_valid_q && !b_valid_q;
  assign count_o      = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      count_q   <= '0;
    end else begin
      state_q   <= state_d;
      a_valid_q <= issue;
      b_valid_q <= a_valid_q;
      if (state_q == ST_IDLE && start_i) begin
        count_q <= '0;
      end else if (beat_o.valid && count_q != 16'hFFFF) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    if (state_q == ST_IDLE && start_i) begin
      shape_q <= cmd_i.kind[2:1];
      px_q    <= cmd_i.pos_x;
      py_q    <= cmd_i.pos_y;
      pz_q    <= cmd_i.pos_z;
      sx_q    <= cmd_i.span_x;
      sy_q    <= (cmd_i.kind[2:1] == vsf_pkg::SHAPE_SPHERE) ? cmd_i.span_x : cmd_i.span_y;
      sz_q    <= (cmd_i.kind[2:1] == vsf_pkg::SHAPE_SPHERE) ? cmd_i.span_x : cmd_i.span_z;
    end
    if (state_q == ST_SQ) begin
      lo_x_q  <= lo_x;
      lo_y_q  <= lo_y;
      lo_z_q  <= lo_z;
      hi_x_q  <= hi_x;
      hi_y_q  <= hi_y;
      hi_z_q  <= hi_z;
      ax_q    <= 10'(sx_q) * 10'(sx_q);
      ay_q    <= 10'(sy_q) * 10'(sy_q);
      az_q    <= 10'(sz_q) * 10'(sz_q);
      empty_q <= (lo_x > hi_x) || (lo_y > hi_y) || (lo_z > hi_z) ||
                 ((shape_q == vsf_pkg::SHAPE_ELLIPSOID) &&
                  (sx_q == '0 || sy_q == '0 || sz_q == '0));
    end
    if (state_q == ST_PROD) begin
      ayaz_q <= 20'(ay_q) * 20'(az_q);
      axaz_q <= 20'(ax_q) * 20'(az_q);
      axay_q <= 20'(ax_q) * 20'(ay_q);
    end
    if (state_q == ST_LIM) begin
      lim_q <= 30'(ax_q) * 30'(ayaz_q);
    end
    a_x_q   <= x_q;
    a_y_q   <= y_q;
    a_z_q   <= z_q;
    a_dx2_q <= 10'(dxa[4:0]) * 10'(dxa[4:0]);
    a_dy2_q <= 10'(dya[4:0]) * 10'(dya[4:0]);
    a_dz2_q <= 10'(dza[4:0]) * 10'(dza[4:0]);
    b_x_q   <= a_x_q;
    b_y_q   <= a_y_q;
    b_z_q   <= a_z_q;
    b_sum_q <= 12'(a_dx2_q) + 12'(a_dy2_q) + 12'(a_dz2_q);
    b_tx_q  <= 30'(a_dx2_q) * 30'(ayaz_q);
    b_ty_q  <= 30'(a_dy2_q) * 30'(axaz_q);
    b_tz_q  <= 30'(a_dz2_q) * 30'(axay_q);
  end

endmodule

// ----- rtl/voxel_shape_fill_engine.sv -----
// ----------------------------------------------------------------------------
// voxel_shape_fill_engine
// A fill or cut sets up its bounds, scans every voxel of the clipped bounding box
// and drains the shape test; a read reads the store unless it is off the grid.
// One command at a time; the next is taken once the result is registered.
// After reset the occupancy memory is swept, with input stalled; paint registers
// reset to zero.
// ----------------------------------------------------------------------------
`include "voxel_shape_fill_engine_defines.svh"

module voxel_shape_fill_engine #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  vsf_pkg::cmd_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output vsf_pkg::res_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [8:0] GX = 9'(GRID_X);
  localparam logic [8:0] GY = 9'(GRID_Y);
  localparam logic [8:0] GZ = 9'(GRID_Z);

  logic [1:0]     state_q;
  logic [7:0]     red_q, green_q, blue_q, alpha_q;
  logic           fill_q;
  vsf_pkg::res_t  res_q, out_q;
  logic           out_valid_q;
  logic           accept, in_grid, draw, scan_done, store_busy, rd_on, load;
  logic [15:0]    scan_count;
  logic [31:0]    rd_colour;
  vsf_pkg::beat_t wr_beat, rd_beat;

  assign in_stall_o = (state_q != ST_IDLE) || store_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign draw       = (in_data_i.kind <= vsf_pkg::KIND_LAST_DRAW);
  assign in_grid    = (9'(in_data_i.pos_x) < GX) && (9'(in_data_i.pos_y) < GY) &&
                      (9'(in_data_i.pos_z) < GZ);

  assign rd_beat.valid = accept && (in_data_i.kind == vsf_pkg::KIND_READ) && in_grid;
  assign rd_beat.x     = 8'(in_data_i.pos_x);
  assign rd_beat.y     = 8'(in_data_i.pos_y);
  assign rd_beat.z     = 8'(in_data_i.pos_z);

  assign load = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  vsf_scan #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept && draw),
    .cmd_i  (in_data_i),
    .beat_o (wr_beat),
    .done_o (scan_done),
    .count_o(scan_count)
  );

  vsf_store #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y),
    .GRID_Z(GRID_Z)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .busy_o     (store_busy),
    .wr_i       (wr_beat),
    .fill_i     (fill_q),
    .colour_i   ({alpha_q, blue_q, green_q, red_q}),
    .rd_i       (rd_beat),
    .rd_on_o    (rd_on),
    .rd_colour_o(rd_colour)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      alpha_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          vsf_pkg::REG_RED:   red_q   <= cfg_wdata_i;
          vsf_pkg::REG_GREEN: green_q <= cfg_wdata_i;
          vsf_pkg::REG_BLUE:  blue_q  <= cfg_wdata_i;
          vsf_pkg::REG_ALPHA: alpha_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (draw) begin
              state_q <= ST_RUN;
            end else if (rd_beat.valid) begin
              state_q <= ST_READ;
            end else begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_RUN: begin
          if (scan_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_READ: state_q <= ST_DONE;
        ST_DONE: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= '0;
      fill_q <= ~in_data_i.kind[0];
    end else if (state_q == ST_RUN && scan_done) begin
      res_q.touched_count <= scan_count;
    end else if (state_q == ST_READ) begin
      res_q.voxel_on  <= rd_on;
      res_q.out_red   <= rd_on ? rd_colour[7:0]   : 8'h00;
      res_q.out_green <= rd_on ? rd_colour[15:8]  : 8'h00;
      res_q.out_blue  <= rd_on ? rd_colour[23:16] : 8'h00;
      res_q.out_alpha <= rd_on ? rd_colour[31:24] : 8'h00;
    end
    if (load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `VSF_ASSERT(a_done_in_run, scan_done |-> state_q == ST_RUN)
  `VSF_ASSERT(a_read_follows, rd_beat.valid |=> state_q == ST_READ)
  `VSF_ASSERT_RST(a_stall_in_clear, store_busy |-> in_stall_o)

endmodule

// ----- dv/voxel_shape_fill_engine_checker.sv -----
// ----------------------------------------------------------------------------
// voxel_shape_fill_engine_checker
// Watches the command, result and paint register ports of the voxel engine.
// Keeps its own voxel grid and paint state, works out the result of each
// accepted command and compares it with the result beats.
// ----------------------------------------------------------------------------
module voxel_shape_fill_engine_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  vsf_pkg::cmd_t in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  vsf_pkg::res_t out_data_i,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [7:0]    cfg_wdata_i,
  output int            pending_o,
  output int            errors_o
);
  import vsf_pkg::*;

  localparam int GRID = 32;
  localparam int CELLS = GRID * GRID * GRID;

  bit          grid_on [CELLS];
  logic [31:0] grid_rgba [CELLS];
  logic [7:0]  paint [4];
  res_t        results_due [$];

  function automatic res_t apply_command(cmd_t c);
    res_t       r;
    logic [1:0] shape;
    bit         fill, hit;
    int         px, py, pz, sx, sy, sz, x0, x1, y0, y1, z0, z1, at;
    longint unsigned ax, ay, az, dx, dy, dz, cnt;
    r = '0;
    cnt = 0;
    px = c.pos_x; py = c.pos_y; pz = c.pos_z;
    sx = c.span_x; sy = c.span_y; sz = c.span_z;
    if (c.kind == KIND_READ) begin
      at = (px * GRID + py) * GRID + pz;
      if (grid_on[at]) begin
        r.voxel_on  = 1'b1;
        r.out_red   = grid_rgba[at][7:0];
        r.out_green = grid_rgba[at][15:8];
        r.out_blue  = grid_rgba[at][23:16];
        r.out_alpha = grid_rgba[at][31:24];
      end
      return r;
    end
    if (c.kind > KIND_LAST_DRAW) return r;
    shape = c.kind[2:1];
    fill  = !c.kind[0];
    if (shape == SHAPE_BOX) begin
      x0 = px; x1 = sx; y0 = py; y1 = sy; z0 = pz; z1 = sz;
    end else begin
      if (shape == SHAPE_SPHERE) begin
        sy = sx; sz = sx;
      end else if (sx == 0 || sy == 0 || sz == 0) begin
        return r;
      end
      x0 = px - sx; x1 = px + sx;
      y0 = py - sy; y1 = py + sy;
      z0 = pz - sz; z1 = pz + sz;
    end
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (z0 < 0) z0 = 0;
    if (x1 > GRID - 1) x1 = GRID - 1;
    if (y1 > GRID - 1) y1 = GRID - 1;
    if (z1 > GRID - 1) z1 = GRID - 1;
    ax = sx * sx; ay = sy * sy; az = sz * sz;
    for (int x = x0; x <= x1; x++) begin
      for (int y = y0; y <= y1; y++) begin
        for (int z = z0; z <= z1; z++) begin
          dx = (x > px) ? x - px : px - x;
          dy = (y > py) ? y - py : py - y;
          dz = (z > pz) ? z - pz : pz - z;
          if (shape == SHAPE_BOX) hit = 1'b1;
          else if (shape == SHAPE_SPHERE) hit = (dx * dx + dy * dy + dz * dz <= ax);
          else hit = (dx * dx * ay * az + dy * dy * ax * az + dz * dz * ax * ay
                      <= ax * ay * az);
          if (hit) begin
            at = (x * GRID + y) * GRID + z;
            grid_on[at] = fill;
            if (fill) grid_rgba[at] = {paint[3], paint[2], paint[1], paint[0]};
            if (cnt < 65535) cnt++;
          end
        end
      end
    end
    r.touched_count = cnt[15:0];
    return r;
  endfunction

  assign pending_o = results_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got, want;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) begin
        grid_on[i]   = 1'b0;
        grid_rgba[i] = '0;
      end
      for (int i = 0; i < 4; i++) paint[i] = '0;
      results_due.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (results_due.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            errors_o++;
            if (errors_o <= 10) $display("result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) results_due.push_back(apply_command(in_data_i));
      if (cfg_we_i && cfg_idx_i <= REG_ALPHA) paint[cfg_idx_i] = cfg_wdata_i;
    end
  end

endmodule

// ----- dv/voxel_shape_fill_engine_tb.sv -----
// ----------------------------------------------------------------------------
// voxel_shape_fill_engine_tb
// Drives directed and random shape commands and reads into the voxel engine
// under random sender and receiver idling, across several paint settings.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module voxel_shape_fill_engine_tb;
  import vsf_pkg::*;

  localparam logic [2:0] FILL_BOX  = 3'd0;
  localparam logic [2:0] CUT_BOX   = 3'd1;
  localparam logic [2:0] FILL_SPH  = 3'd2;
  localparam logic [2:0] CUT_SPH   = 3'd3;
  localparam logic [2:0] FILL_ELL  = 3'd4;
  localparam logic [2:0] CUT_ELL   = 3'd5;
  localparam logic [2:0] NO_OP     = 3'd7;
  localparam int         MAX_CYCLES = 20000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  cmd_t       in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  res_t       out_data_o;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [7:0] cfg_wdata_i = '0;
  int         pending, errors, cycles = 0, stall_left = 0;
  bit         calm = 1'b0;
  logic [4:0] last_x, last_y, last_z;

  voxel_shape_fill_engine dut (.*);

  voxel_shape_fill_engine_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .pending_o(pending), .errors_o(errors)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("voxel_shape_fill_engine_tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic send_cmd(input logic [2:0] k, input logic [4:0] px, py, pz, sx, sy, sz);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{k, px, py, pz, sx, sy, sz};
    if (k <= CUT_ELL) begin
      last_x = px; last_y = py; last_z = pz;
    end
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic set_paint(input logic [7:0] r, g, b, a);
    logic [7:0] v [4];
    v = '{r, g, b, a};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= v[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_cmd();
    int         r;
    logic [2:0] k;
    logic [4:0] px, py, pz;
    r  = $urandom_range(0, 99);
    px = 5'($urandom); py = 5'($urandom); pz = 5'($urandom);
    k  = 3'($urandom_range(0, 5));
    if (r < 30) begin
      if (r < 20) begin
        px = last_x + 5'($urandom_range(0, 4)) - 5'd2;
        py = last_y + 5'($urandom_range(0, 4)) - 5'd2;
        pz = last_z + 5'($urandom_range(0, 4)) - 5'd2;
      end
      send_cmd(KIND_READ, px, py, pz, 5'($urandom), 5'($urandom), 5'($urandom));
    end else if (r < 33) begin
      send_cmd(NO_OP, px, py, pz, 5'($urandom), 5'($urandom), 5'($urandom));
    end else if (r < 37) begin
      send_cmd(k, px, py, pz, 5'($urandom), 5'($urandom), 5'($urandom));
    end else if (k <= CUT_BOX) begin
      send_cmd(k, px, py, pz, px + 5'($urandom_range(0, 4)), py + 5'($urandom_range(0, 4)),
               pz + 5'($urandom_range(0, 4)));
    end else begin
      send_cmd(k, px, py, pz, 5'($urandom_range(0, 4)), 5'($urandom_range(0, 4)),
               5'($urandom_range(0, 4)));
    end
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= 3'd5; cfg_wdata_i <= 8'hff;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    set_paint(8'hff, 8'h00, 8'hff, 8'h00);

    send_cmd(KIND_READ, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(FILL_BOX, 5'd0, 5'd0, 5'd0, 5'd31, 5'd31, 5'd31);
    send_cmd(KIND_READ, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31);
    send_cmd(CUT_BOX, 5'd9, 5'd2, 5'd2, 5'd4, 5'd8, 5'd8);
    send_cmd(CUT_SPH, 5'd5, 5'd6, 5'd7, 5'd0, 5'd9, 5'd9);
    send_cmd(KIND_READ, 5'd5, 5'd6, 5'd7, 5'd0, 5'd0, 5'd0);
    send_cmd(KIND_READ, 5'd5, 5'd6, 5'd8, 5'd0, 5'd0, 5'd0);
    send_cmd(CUT_SPH, 5'd0, 5'd0, 5'd0, 5'd31, 5'd0, 5'd0);
    send_cmd(KIND_READ, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
    send_cmd(FILL_ELL, 5'd16, 5'd16, 5'd16, 5'd0, 5'd5, 5'd5);
    send_cmd(FILL_ELL, 5'd16, 5'd16, 5'd16, 5'd3, 5'd5, 5'd2);
    send_cmd(KIND_READ, 5'd16, 5'd21, 5'd16, 5'd0, 5'd0, 5'd0);
    send_cmd(KIND_READ, 5'd19, 5'd16, 5'd17, 5'd0, 5'd0, 5'd0);
    send_cmd(CUT_ELL, 5'd30, 5'd1, 5'd16, 5'd31, 5'd31, 5'd31);
    send_cmd(FILL_SPH, 5'd31, 5'd31, 5'd0, 5'd4, 5'd0, 5'd0);
    send_cmd(NO_OP, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31);
    send_cmd(FILL_BOX, 5'd31, 5'd0, 5'd31, 5'd31, 5'd0, 5'd31);
    send_cmd(KIND_READ, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0);
    send_cmd(CUT_BOX, 5'd31, 5'd0, 5'd31, 5'd31, 5'd0, 5'd31);
    send_cmd(KIND_READ, 5'd31, 5'd0, 5'd31, 5'd0, 5'd0, 5'd0);
    drain();

    set_paint(8'h00, 8'hff, 8'h00, 8'hff);
    for (int i = 0; i < 50; i++) random_cmd();
    drain();

    set_paint(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    for (int i = 0; i < 50; i++) begin
      if (i == 35) calm = 1'b1;
      random_cmd();
    end
    drain();

    if (errors == 0) begin
      $display("voxel_shape_fill_engine_tb OK");
    end else begin
      $display("voxel_shape_fill_engine_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- voxel_shape_fill_engine.f -----
+incdir+rtl
rtl/vsf_pkg.sv
rtl/vsf_store.sv
rtl/vsf_scan.sv
rtl/voxel_shape_fill_engine.sv
dv/voxel_shape_fill_engine_checker.sv
dv/voxel_shape_fill_engine_tb.sv
